/* rtl/nll_pkg.sv */
// Package with constants and types of the ladder lowpass.
package nll_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int STATE_BITS_DEF = 32;
    localparam int TANH_FRAC = 24;
    localparam int CFG_BITS = 18;
    localparam int COEF_BITS = 18;
    localparam int QUO_BITS = 34;
    localparam logic [COEF_BITS-1:0] COEF_ONE = 18'd65536;

    localparam logic [1:0] REG_CUTOFF = 2'd0;
    localparam logic [1:0] REG_MODULATION = 2'd1;
    localparam logic [1:0] REG_RESONANCE = 2'd2;
    localparam logic [1:0] REG_SAMPLE_RATE = 2'd3;

    localparam logic [14:0] TAP_W0 = 15'd23651;
    localparam logic [14:0] TAP_W1 = 15'd27348;
    localparam logic [14:0] TAP_W2 = 15'd11659;
    localparam logic [14:0] TAP_W3 = 15'd2882;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_TAPS   = 10'b0000000010,
        ST_FB     = 10'b0000000100,
        ST_SQ     = 10'b0000001000,
        ST_DIV    = 10'b0000010000,
        ST_TMUL   = 10'b0000100000,
        ST_STEP   = 10'b0001000000,
        ST_OUT    = 10'b0010000000,
        ST_COEF   = 10'b0100000000,
        ST_CDIV   = 10'b1000000000
    } nll_state_t;

endpackage

/* rtl/nll_div.sv */
// Shared restoring divider, one quotient bit per cycle.
module nll_div #(
    parameter int NUM_BITS = 56,
    parameter int DEN_BITS = 32,
    parameter int QUO_BITS = 26
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_BITS-1:0] num,
    input  logic [DEN_BITS-1:0] den,
    output logic                busy,
    output logic [QUO_BITS-1:0] quo
);
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] num_reg;
    logic [DEN_BITS:0] rem_reg;
    logic [QUO_BITS-1:0] quo_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [DEN_BITS-1:0] den_reg;
    logic [DEN_BITS+1:0] trial;
    logic [DEN_BITS:0] shifted;

    assign shifted = {rem_reg[DEN_BITS-1:0], num_reg[NUM_BITS-1]};
    assign trial = {1'b0, shifted} - {2'b00, den_reg};
    assign busy = (cnt_reg != '0);
    assign quo = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_BITS'(NUM_BITS);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy)
        begin
            num_reg <= {num_reg[NUM_BITS-2:0], 1'b0};
            if (!trial[DEN_BITS+1])
            begin
                rem_reg <= trial[DEN_BITS:0];
                quo_reg <= {quo_reg[QUO_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[QUO_BITS-2:0], 1'b0};
            end
        end
    end
endmodule

/* rtl/nonlinear_ladder_lowpass.sv */
// Top level of the four-pole nonlinear ladder lowpass with its sequencer.
//  channel | direction | handshake     | payload
//  in      | request   | valid / stall | cmd, sample_in
//  out     | result    | valid / stall | sample_out
//  cfg     | write     | cfg_we        | cfg_index, cfg_data
// A filter request gives its result after eight tanh evaluations, each bound by the
// shared divider, and the tap, feedback, step and output work on the one shared
// multiplier. A new request is not taken until the last result has been taken. A clear
// request gives its result in the cycle after acceptance. A configuration write holds off
// requests while the coefficient is updated, if need be by a division on the same
// divider. Reset zeroes all stages.
// in_stall is high while a request is in work, a result waits or the coefficient updates.
module nonlinear_ladder_lowpass (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  logic                                      cmd,
    input  logic signed [nll_pkg::SAMPLE_BITS_DEF-1:0] sample_in,
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic signed [nll_pkg::SAMPLE_BITS_DEF-1:0] sample_out,
    input  logic                                      cfg_we,
    input  logic [1:0]                                cfg_index,
    input  logic [nll_pkg::CFG_BITS-1:0]              cfg_data
);
    localparam int SAMPLE_BITS = nll_pkg::SAMPLE_BITS_DEF;
    localparam int STATE_BITS = nll_pkg::STATE_BITS_DEF;
    localparam int SF = SAMPLE_BITS - 1;
    localparam int XF = STATE_BITS - 8;
    localparam int W = 72;
    localparam int NB = 63;
    localparam int DB = 42;
    localparam int QB = nll_pkg::QUO_BITS;

    typedef logic signed [W-1:0] wide_t;

    nll_pkg::nll_state_t state_reg;
    logic [2:0] sub_reg;
    logic [2:0] idx_reg;
    logic signed [STATE_BITS-1:0] stage_reg [4];
    logic signed [STATE_BITS-1:0] dly_reg [3];
    logic signed [STATE_BITS-1:0] x_reg, y_reg, prev_reg, targ_reg;
    wide_t acc_reg;
    logic signed [33:0] q_reg;
    logic [38:0] x2_reg;
    logic [nll_pkg::COEF_BITS-1:0] coef_reg;
    logic [16:0] cutoff_reg, res_reg;
    logic signed [16:0] mod_reg;
    logic [17:0] rate_reg;
    logic coef_pend_reg;
    logic out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_reg;

    logic div_start;
    logic div_busy;
    logic [NB-1:0] dnum;
    logic [DB-1:0] dden;
    logic [QB-1:0] dquo;

    logic signed [36:0] mul_a;
    logic signed [36:0] mul_b;
    logic signed [73:0] mul_p;
    assign mul_p = mul_a * mul_b;

    nll_div #(.NUM_BITS(NB), .DEN_BITS(DB), .QUO_BITS(QB)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(dnum), .den(dden),
        .busy(div_busy), .quo(dquo)
    );

    function automatic wide_t rshr(input wide_t v, input int s);
        wide_t r;
        r = v + (wide_t'(1) <<< (s - 1));
        return r >>> s;
    endfunction

    function automatic logic signed [STATE_BITS-1:0] sat_st(input wide_t v);
        wide_t hi;
        wide_t lo;
        hi = (wide_t'(1) <<< (STATE_BITS - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi[STATE_BITS-1:0];
        else if (v < lo) return lo[STATE_BITS-1:0];
        else return v[STATE_BITS-1:0];
    endfunction

    function automatic wide_t rescale(input wide_t v, input int from, input int to);
        if (to >= from) return v <<< (to - from);
        else return rshr(v, from - to);
    endfunction

    logic signed [18:0] csum;
    assign csum = $signed({2'b00, cutoff_reg}) + 19'(mod_reg);

    wide_t tanh_res;
    always_comb
    begin
        wide_t hi, lo, s;
        hi = (wide_t'(1) <<< 31) - 1;
        lo = -hi - 1;
        s = rescale(wide_t'(targ_reg), XF, nll_pkg::TANH_FRAC);
        if (s > hi) s = hi;
        else if (s < lo) s = lo;
        tanh_res = s;
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            nll_pkg::ST_TAPS:
            begin
                unique case (sub_reg)
                    3'd0: begin mul_a = 37'(stage_reg[3]); mul_b = 37'(nll_pkg::TAP_W0); end
                    3'd1: begin mul_a = 37'(dly_reg[0]); mul_b = 37'(nll_pkg::TAP_W1); end
                    3'd2: begin mul_a = 37'(dly_reg[1]); mul_b = 37'(nll_pkg::TAP_W2); end
                    default: begin mul_a = 37'(dly_reg[2]); mul_b = 37'(nll_pkg::TAP_W3); end
                endcase
            end
            nll_pkg::ST_FB:
            begin
                mul_a = 37'(y_reg);
                mul_b = 37'({res_reg, 2'b00});
            end
            nll_pkg::ST_SQ:
            begin
                mul_a = 37'(q_reg);
                mul_b = 37'(q_reg);
            end
            nll_pkg::ST_TMUL:
            begin
                mul_a = 37'(targ_reg);
                mul_b = 37'($signed({1'b0, dquo}));
            end
            nll_pkg::ST_STEP:
            begin
                mul_a = 37'($signed(acc_reg[STATE_BITS+1:0]));
                mul_b = 37'($signed({1'b0, coef_reg}));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign in_stall = (state_reg != nll_pkg::ST_IDLE) || out_valid_reg || coef_pend_reg
                      || div_busy;
    assign out_valid = out_valid_reg;
    assign sample_out = out_reg;

    always_comb
    begin
        div_start = 1'b0;
        dnum = '0;
        dden = '0;
        if (state_reg == nll_pkg::ST_SQ && sub_reg == 3'd1)
        begin
            div_start = 1'b1;
            dnum = NB'((39'(27) << 24) + x2_reg) << 24;
            dden = DB'((42'(27) << 24) + 42'(9) * 42'(x2_reg));
        end
        else if (state_reg == nll_pkg::ST_COEF)
        begin
            div_start = 1'b1;
            dnum = NB'($unsigned(csum[17:0]) * 34'd44100);
            dden = DB'(rate_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nll_pkg::ST_IDLE;
            sub_reg <= '0;
            idx_reg <= '0;
            out_valid_reg <= 1'b0;
            coef_pend_reg <= 1'b0;
            coef_reg <= nll_pkg::COEF_ONE;
            cutoff_reg <= 17'd65536;
            mod_reg <= '0;
            res_reg <= 17'd6554;
            rate_reg <= 18'd44100;
            x_reg <= '0;
            y_reg <= '0;
            prev_reg <= '0;
            targ_reg <= '0;
            acc_reg <= '0;
            q_reg <= '0;
            x2_reg <= '0;
            out_reg <= '0;
            for (int i = 0; i < 4; i++) stage_reg[i] <= '0;
            for (int i = 0; i < 3; i++) dly_reg[i] <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    nll_pkg::REG_CUTOFF: cutoff_reg <= cfg_data[16:0];
                    nll_pkg::REG_MODULATION: mod_reg <= $signed(cfg_data[16:0]);
                    nll_pkg::REG_RESONANCE: res_reg <= cfg_data[16:0];
                    default: rate_reg <= cfg_data;
                endcase
                coef_pend_reg <= 1'b1;
            end
            unique case (state_reg)
                nll_pkg::ST_IDLE:
                begin
                    if (coef_pend_reg && !cfg_we && !div_busy)
                    begin
                        coef_pend_reg <= 1'b0;
                        if (csum <= 0)
                            coef_reg <= '0;
                        else if (rate_reg == '0)
                            coef_reg <= nll_pkg::COEF_ONE;
                        else
                            state_reg <= nll_pkg::ST_COEF;
                    end
                    else if (in_valid && !in_stall)
                    begin
                        if (cmd)
                        begin
                            for (int i = 0; i < 4; i++) stage_reg[i] <= '0;
                            for (int i = 0; i < 3; i++) dly_reg[i] <= '0;
                            out_reg <= '0;
                            out_valid_reg <= 1'b1;
                        end
                        else
                        begin
                            x_reg <= sat_st(rescale(wide_t'(sample_in), SF, XF));
                            acc_reg <= '0;
                            sub_reg <= '0;
                            state_reg <= nll_pkg::ST_TAPS;
                        end
                    end
                end
                nll_pkg::ST_COEF:
                    state_reg <= nll_pkg::ST_CDIV;
                nll_pkg::ST_CDIV:
                begin
                    if (!div_busy)
                    begin
                        coef_reg <= (dquo > QB'(nll_pkg::COEF_ONE)) ? nll_pkg::COEF_ONE
                                    : dquo[nll_pkg::COEF_BITS-1:0];
                        state_reg <= nll_pkg::ST_IDLE;
                    end
                end
                nll_pkg::ST_TAPS:
                begin
                    acc_reg <= acc_reg + wide_t'(mul_p);
                    sub_reg <= sub_reg + 1'b1;
                    if (sub_reg == 3'd3)
                    begin
                        state_reg <= nll_pkg::ST_FB;
                        sub_reg <= '0;
                    end
                end
                nll_pkg::ST_FB:
                begin
                    if (sub_reg == 3'd0)
                    begin
                        y_reg <= sat_st(rshr(acc_reg, 16));
                        dly_reg[2] <= dly_reg[1];
                        dly_reg[1] <= dly_reg[0];
                        dly_reg[0] <= stage_reg[3];
                        sub_reg <= 3'd1;
                    end
                    else
                    begin
                        targ_reg <= sat_st(wide_t'(x_reg) - rshr(wide_t'(mul_p), 16));
                        idx_reg <= '0;
                        sub_reg <= '0;
                        state_reg <= nll_pkg::ST_SQ;
                    end
                end
                nll_pkg::ST_SQ:
                begin
                    if (sub_reg == 3'd0)
                    begin
                        q_reg <= 34'(tanh_res);
                        sub_reg <= 3'd2;
                    end
                    else if (sub_reg == 3'd2)
                    begin
                        x2_reg <= 39'(rshr(wide_t'(mul_p), 24));
                        sub_reg <= 3'd1;
                    end
                    else
                    begin
                        sub_reg <= '0;
                        state_reg <= nll_pkg::ST_DIV;
                    end
                end
                nll_pkg::ST_DIV:
                    if (!div_busy)
                        state_reg <= nll_pkg::ST_TMUL;
                nll_pkg::ST_TMUL:
                begin
                    // Even passes give prev; odd passes give t(stage i).
                    if (idx_reg[0] == 1'b0)
                    begin
                        prev_reg <= sat_st(rshr(wide_t'(mul_p), 24));
                        targ_reg <= stage_reg[idx_reg[2:1]];
                        idx_reg <= idx_reg + 1'b1;
                        state_reg <= nll_pkg::ST_SQ;
                    end
                    else
                    begin
                        acc_reg <= wide_t'(prev_reg)
                                   - wide_t'(sat_st(rshr(wide_t'(mul_p), 24)));
                        state_reg <= nll_pkg::ST_STEP;
                    end
                end
                nll_pkg::ST_STEP:
                begin
                    stage_reg[idx_reg[2:1]] <= sat_st(wide_t'(stage_reg[idx_reg[2:1]])
                                                      + rshr(wide_t'(mul_p), 16));
                    targ_reg <= sat_st(wide_t'(stage_reg[idx_reg[2:1]])
                                       + rshr(wide_t'(mul_p), 16));
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == 3'd7)
                        state_reg <= nll_pkg::ST_OUT;
                    else
                        state_reg <= nll_pkg::ST_SQ;
                end
                nll_pkg::ST_OUT:
                begin
                    begin : out_sat
                        wide_t v, hi, lo;
                        v = rescale(wide_t'(y_reg), XF, SF);
                        hi = (wide_t'(1) <<< (SAMPLE_BITS - 1)) - 1;
                        lo = -hi - 1;
                        if (v > hi) v = hi;
                        else if (v < lo) v = lo;
                        out_reg <= v[SAMPLE_BITS-1:0];
                    end
                    out_valid_reg <= 1'b1;
                    state_reg <= nll_pkg::ST_IDLE;
                end
                default:
                    state_reg <= nll_pkg::ST_IDLE;
            endcase
        end
    end
endmodule
